[rtl/qpu_pkg.sv]
// ----------------------------------------------------------------------------
// qpu_pkg: shared types and constants of the pose update block
// Operand widths of the shared multiplier, CORDIC constants, the Hamilton
// product term table and saturation helpers.
// ----------------------------------------------------------------------------
package qpu_pkg;

   localparam int OPA_W = 19;
   localparam int OPB_W = 42;
   localparam int ACC_W = 61;
   localparam int CRD_W = 34;
   localparam int SC_W  = 18;

   localparam int CORDIC_STEPS = 16;
   localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // half turn in 1/512 degree and the reciprocal giving floor(r * 2^20 / 45)
   localparam logic [20:0] HALF_TURN = 21'd184320;
   localparam logic [20:0] WRAP_BIAS = 21'd552960;
   localparam logic signed [OPB_W-1:0] RECIP_M = 42'sd390937467654;

   localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
   };

   // Hamilton product rot * orient: component, term -> rot index, orient index
   localparam logic [1:0] HAM_A [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd0, 2'd1, 2'd2, 2'd3}
   };
   localparam logic [1:0] HAM_B [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3}, '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd2, 2'd3, 2'd0, 2'd1}, '{2'd3, 2'd2, 2'd1, 2'd0}
   };
   // bit k set: term k is subtracted
   localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

   typedef struct packed {
      logic issue;
      logic first;
      logic neg;
   } mac_ctrl_type;

   function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
      logic signed [15:0] r;
      if (v > 61'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -61'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
      logic signed [31:0] r;
      if (v > 43'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -43'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[rtl/qpu_mac.sv]
// ----------------------------------------------------------------------------
// qpu_mac: shared multiply-accumulate unit
// One registered signed multiplier followed by an accumulator that adds or
// subtracts each product; the first term of a group restarts the sum.
// ----------------------------------------------------------------------------
module qpu_mac import qpu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  mac_ctrl_type            ctrl,
   input  logic signed [OPA_W-1:0] op_a,
   input  logic signed [OPB_W-1:0] op_b,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [ACC_W-1:0] prod_ff, acc_ff, acc_in;
   mac_ctrl_type            pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.issue) begin
         prod_ff <= ACC_W'(op_a) * ACC_W'(op_b);
      end
      if (pend_ff.issue) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      acc_in = pend_ff.first ? '0 : acc_ff;
      acc_in = pend_ff.neg ? acc_in - prod_ff : acc_in + prod_ff;
   end

   assign acc = acc_ff;

endmodule

[rtl/qpu_cordic.sv]
// ----------------------------------------------------------------------------
// qpu_cordic: iterative half-angle sine and cosine
// Sixteen rotation-mode steps, one per cycle, through one shift-add unit;
// results are rounded to Q2.14 and negated for folded phases.
// ----------------------------------------------------------------------------
module qpu_cordic import qpu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [CRD_W-1:0] phase,
   input  logic                   negate,
   output logic                   done,
   output logic signed [SC_W-1:0] cos_q,
   output logic signed [SC_W-1:0] sin_q
);

   logic signed [CRD_W-1:0] x_ff, y_ff, z_ff, x_in, y_in, z_in, dx, dy, at;
   logic [3:0]              step_ff;
   logic                    busy_ff, done_ff, neg_ff;
   logic signed [CRD_W-1:0] xr, yr;

   always_comb begin
      dx = y_ff >>> step_ff;
      dy = x_ff >>> step_ff;
      at = CRD_W'(ATAN_TURN[step_ff]);
      if (!z_ff[CRD_W-1]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == 4'(CORDIC_STEPS - 1));
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'(CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= CORDIC_GAIN;
         y_ff   <= '0;
         z_ff   <= phase;
         neg_ff <= negate;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   always_comb begin
      xr = (x_ff + 34'sd32768) >>> 16;
      yr = (y_ff + 34'sd32768) >>> 16;
      cos_q = neg_ff ? -xr[SC_W-1:0] : xr[SC_W-1:0];
      sin_q = neg_ff ? -yr[SC_W-1:0] : yr[SC_W-1:0];
   end

   assign done = done_ff;

endmodule

[rtl/quaternion_pose_update.sv]
// ----------------------------------------------------------------------------
// quaternion_pose_update: rigid pose store with translate and rotate commands
// From the input beat to the result beat: a world translation adds the vector
// to the position, a local translation first turns it by the orientation, and
// a rotation takes up to five wrap steps and 16 CORDIC steps, then axis scaling
// and the Hamilton product, one multiply at a time through the shared multiplier.
// One item at a time; the next beat is taken once the block is back in idle.
// Synchronous reset puts the pose at the origin with the identity orientation.
// ----------------------------------------------------------------------------
module quaternion_pose_update import qpu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // vec_x, vec_y, vec_z, angle_degrees, zero pad
   input  logic [1:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata   // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_TVEC   = 4'd1;
   localparam logic [3:0] S_RVEC   = 4'd2;
   localparam logic [3:0] S_MOD    = 4'd3;
   localparam logic [3:0] S_PHASE  = 4'd4;
   localparam logic [3:0] S_CORDIC = 4'd5;
   localparam logic [3:0] S_AXIS   = 4'd6;
   localparam logic [3:0] S_HAM    = 4'd7;
   localparam logic [3:0] S_TRANS  = 4'd8;
   localparam logic [3:0] S_FIN    = 4'd9;

   logic [3:0]               state_ff;
   logic [1:0]               grp_ff;
   logic [2:0]               stp_ff;
   logic [1:0]               cmd_ff;
   logic signed [31:0]       vec_ff [3];
   logic signed [31:0]       pos_ff [3];
   logic signed [15:0]       quat_ff [4];
   logic signed [15:0]       qn_ff [3];
   logic signed [37:0]       t_ff [3];
   logic signed [OPB_W-1:0]  rv_ff [3];
   logic signed [SC_W-1:0]   rq_ff [4];
   logic [20:0]              rem_ff;
   logic                     rsp_valid_ff;
   logic [159:0]             rsp_data_ff;

   mac_ctrl_type             mac_ctrl;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [ACC_W-1:0]  mac_acc, rnd13, rnd14, rnd16;
   logic [2:0]               nterm;
   logic [1:0]               last_grp, i1, i2;
   logic                     in_mac, fin_step, req_fire;
   logic                     cordic_start, cordic_done, cordic_neg;
   logic signed [CRD_W-1:0]  cordic_phase;
   logic signed [SC_W-1:0]   cos_q, sin_q;
   logic [31:0]              ph;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // cross-product index pair for the component in work
   always_comb begin
      unique case (grp_ff)
         2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
         2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
         default: begin i1 = 2'd0; i2 = 2'd1; end
      endcase
   end

   always_comb begin
      nterm    = 3'd1;
      last_grp = 2'd2;
      in_mac   = 1'b1;
      unique case (state_ff)
         S_TVEC:  nterm = 3'd2;
         S_RVEC:  nterm = 3'd3;
         S_PHASE: last_grp = 2'd0;
         S_AXIS:  nterm = 3'd1;
         S_HAM:   begin nterm = 3'd4; last_grp = 2'd3; end
         default: in_mac = 1'b0;
      endcase
      fin_step = in_mac && (stp_ff == nterm + 3'd1);
   end

   // operand selection for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      mac_ctrl.neg = 1'b0;
      unique case (state_ff)
         S_TVEC: begin
            if (!stp_ff[0]) begin
               op_a = OPA_W'(quat_ff[i1 + 2'd1]);
               op_b = OPB_W'(vec_ff[i2]);
            end else begin
               op_a = OPA_W'(quat_ff[i2 + 2'd1]);
               op_b = OPB_W'(vec_ff[i1]);
               mac_ctrl.neg = 1'b1;
            end
         end
         S_RVEC: begin
            unique case (stp_ff[1:0])
               2'd0: begin
                  op_a = OPA_W'(quat_ff[0]);
                  op_b = OPB_W'(t_ff[grp_ff]);
               end
               2'd1: begin
                  op_a = OPA_W'(quat_ff[i1 + 2'd1]);
                  op_b = OPB_W'(t_ff[i2]);
               end
               default: begin
                  op_a = OPA_W'(quat_ff[i2 + 2'd1]);
                  op_b = OPB_W'(t_ff[i1]);
                  mac_ctrl.neg = 1'b1;
               end
            endcase
         end
         S_PHASE: begin
            op_a = OPA_W'({1'b0, rem_ff[17:0]});
            op_b = RECIP_M;
         end
         S_AXIS: begin
            op_a = OPA_W'(sin_q);
            op_b = rv_ff[grp_ff];
         end
         S_HAM: begin
            op_a = OPA_W'(rq_ff[HAM_A[grp_ff][stp_ff[1:0]]]);
            op_b = OPB_W'(quat_ff[HAM_B[grp_ff][stp_ff[1:0]]]);
            mac_ctrl.neg = HAM_NEG[grp_ff][stp_ff[1:0]];
         end
         default: ;
      endcase
      mac_ctrl.issue = in_mac && (stp_ff < nterm);
      mac_ctrl.first = (stp_ff == 3'd0);
   end

   qpu_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (mac_acc)
   );

   always_comb begin
      rnd13 = (mac_acc + 61'sd4096) >>> 13;
      rnd14 = (mac_acc + 61'sd8192) >>> 14;
      rnd16 = (mac_acc + 61'sd32768) >>> 16;
      ph    = mac_acc[55:24];
      // fold the middle half turn onto the right half-plane
      cordic_neg   = ph[31] ^ ph[30];
      if (cordic_neg) begin
         cordic_phase = $signed({2'b00, ph}) - 34'sh080000000;
      end else if (ph[31]) begin
         cordic_phase = $signed({2'b00, ph}) - 34'sh100000000;
      end else begin
         cordic_phase = $signed({2'b00, ph});
      end
      cordic_start = (state_ff == S_PHASE) && fin_step;
   end

   qpu_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .phase  (cordic_phase),
      .negate (cordic_neg),
      .done   (cordic_done),
      .cos_q  (cos_q),
      .sin_q  (sin_q)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         grp_ff   <= '0;
         stp_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               grp_ff <= '0;
               stp_ff <= '0;
               if (req_fire) begin
                  priority if (req_tuser[0]) begin
                     state_ff <= S_TVEC;
                  end else if (req_tuser[1]) begin
                     state_ff <= S_MOD;
                  end else begin
                     state_ff <= S_TRANS;
                  end
               end
            end
            S_TVEC, S_RVEC, S_PHASE, S_AXIS, S_HAM: begin
               if (fin_step) begin
                  stp_ff <= '0;
                  if (grp_ff == last_grp) begin
                     grp_ff <= '0;
                     unique case (state_ff)
                        S_TVEC:  state_ff <= S_RVEC;
                        S_RVEC:  state_ff <= cmd_ff[1] ? S_MOD : S_TRANS;
                        S_PHASE: state_ff <= S_CORDIC;
                        S_AXIS:  state_ff <= S_HAM;
                        default: state_ff <= S_FIN;
                     endcase
                  end else begin
                     grp_ff <= grp_ff + 2'd1;
                  end
               end else begin
                  stp_ff <= stp_ff + 3'd1;
               end
            end
            S_MOD: begin
               if (rem_ff < HALF_TURN) begin
                  state_ff <= S_PHASE;
               end
            end
            S_CORDIC: begin
               if (cordic_done) begin
                  state_ff <= S_AXIS;
               end
            end
            S_TRANS: state_ff <= S_FIN;
            S_FIN: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff    <= req_tuser;
         vec_ff[0] <= req_tdata[31:0];
         vec_ff[1] <= req_tdata[63:32];
         vec_ff[2] <= req_tdata[95:64];
         rv_ff[0]  <= OPB_W'($signed(req_tdata[31:0]));
         rv_ff[1]  <= OPB_W'($signed(req_tdata[63:32]));
         rv_ff[2]  <= OPB_W'($signed(req_tdata[95:64]));
         rem_ff    <= {req_tdata[115], req_tdata[115:96]} + WRAP_BIAS;
      end
      if (state_ff == S_MOD && rem_ff >= HALF_TURN) begin
         rem_ff <= rem_ff - HALF_TURN;
      end
      if (fin_step && state_ff == S_TVEC) begin
         t_ff[grp_ff] <= rnd13[37:0];
      end
      if (fin_step && state_ff == S_RVEC) begin
         rv_ff[grp_ff] <= OPB_W'(vec_ff[grp_ff]) + rnd14[OPB_W-1:0];
      end
      if (state_ff == S_CORDIC && cordic_done) begin
         rq_ff[0] <= cos_q;
      end
      if (fin_step && state_ff == S_AXIS) begin
         rq_ff[grp_ff + 2'd1] <= SC_W'(sat16(rnd16));
      end
      if (fin_step && state_ff == S_HAM && grp_ff != 2'd3) begin
         qn_ff[grp_ff] <= sat16(rnd14);
      end
   end

   // pose store
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0]  <= '0;
         pos_ff[1]  <= '0;
         pos_ff[2]  <= '0;
         quat_ff[0] <= 16'sd16384;
         quat_ff[1] <= '0;
         quat_ff[2] <= '0;
         quat_ff[3] <= '0;
      end else begin
         if (state_ff == S_TRANS) begin
            for (int i = 0; i < 3; i++) begin
               pos_ff[i] <= sat32(43'(pos_ff[i]) + 43'(rv_ff[i]));
            end
         end
         // commit all four components together once the last is ready
         if (fin_step && state_ff == S_HAM && grp_ff == 2'd3) begin
            quat_ff[0] <= qn_ff[0];
            quat_ff[1] <= qn_ff[1];
            quat_ff[2] <= qn_ff[2];
            quat_ff[3] <= sat16(rnd14);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FIN && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_ff <= {quat_ff[3], quat_ff[2], quat_ff[1], quat_ff[0],
                         pos_ff[2], pos_ff[1], pos_ff[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_quat_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_HAM) |=> $stable({quat_ff[0], quat_ff[1], quat_ff[2], quat_ff[3]}))
      else $error("orientation changed outside the product phase");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_TRANS) |=> $stable({pos_ff[0], pos_ff[1], pos_ff[2]}))
      else $error("position changed outside the translate phase");

   a_cordic_wait: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == S_CORDIC))
      else $error("sine and cosine finished while the sequencer was not waiting");

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for quaternion_pose_update
// Drives directed corner cases, then translate and rotate commands in random bursts. A local pose predictor
// works out the expected pose after each beat. A scoreboard compares every
// result beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef enum logic [1:0] {
   CMD_MOVE_WORLD = 2'd0,
   CMD_MOVE_LOCAL = 2'd1,
   CMD_TURN_WORLD = 2'd2,
   CMD_TURN_LOCAL = 2'd3
} pose_cmd_type;

typedef struct packed {
   logic signed [31:0] pz;
   logic signed [31:0] py;
   logic signed [31:0] px;
   logic signed [15:0] qz;
   logic signed [15:0] qy;
   logic signed [15:0] qx;
   logic signed [15:0] qw;
} pose_type;

class pose_scoreboard_type;
   longint   pos [3];
   longint   ori [4];
   pose_type pending [$];
   int       errors;

   function new();
      pos = '{0, 0, 0};
      ori = '{16384, 0, 0, 0};
      errors = 0;
   endfunction

   static function longint rnd(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   static function longint clip(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function void turn_vec(input longint v [3], output longint o [3]);
      longint t [3];
      t[0] = rnd(2 * (ori[2] * v[2] - ori[3] * v[1]), 14);
      t[1] = rnd(2 * (ori[3] * v[0] - ori[1] * v[2]), 14);
      t[2] = rnd(2 * (ori[1] * v[1] - ori[2] * v[0]), 14);
      o[0] = v[0] + rnd(ori[0] * t[0] + ori[2] * t[2] - ori[3] * t[1], 14);
      o[1] = v[1] + rnd(ori[0] * t[1] + ori[3] * t[0] - ori[1] * t[2], 14);
      o[2] = v[2] + rnd(ori[0] * t[2] + ori[1] * t[1] - ori[2] * t[0], 14);
   endfunction

   function void half_sincos(input longint a, output longint c, output longint s);
      longint atn [16];
      longint r, ph, z, x, y, dx, dy;
      bit flip;
      atn = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
              64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
              64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
              64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
      r = a % 184320;
      if (r < 0) r += 184320;
      ph = (r <<< 32) / 184320;
      flip = 0;
      if (ph >= 64'h40000000 && ph < 64'hC0000000) begin
         z = ph - 64'h80000000;
         flip = 1;
      end else if (ph >= 64'hC0000000) begin
         z = ph - (longint'(1) <<< 32);
      end else begin
         z = ph;
      end
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atn[i];
         end else begin
            x += dx; y -= dy; z += atn[i];
         end
      end
      x = rnd(x, 16);
      y = rnd(y, 16);
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function void note_command(pose_cmd_type cmd, logic [119:0] d);
      longint v [3];
      longint rv [3];
      longint a [4];
      longint b [4];
      longint c, s;
      pose_type p;
      v[0] = longint'($signed(d[31:0]));
      v[1] = longint'($signed(d[63:32]));
      v[2] = longint'($signed(d[95:64]));
      if (cmd == CMD_MOVE_LOCAL || cmd == CMD_TURN_LOCAL) turn_vec(v, rv);
      else rv = v;
      if (cmd == CMD_MOVE_WORLD || cmd == CMD_MOVE_LOCAL) begin
         for (int i = 0; i < 3; i++) pos[i] = clip(pos[i] + rv[i], 32);
      end else begin
         b = ori;
         half_sincos(longint'($signed(d[115:96])), c, s);
         a[0] = c;
         for (int i = 0; i < 3; i++) a[i+1] = clip(rnd(s * rv[i], 16), 16);
         ori[0] = clip(rnd(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], 14), 16);
         ori[1] = clip(rnd(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2], 14), 16);
         ori[2] = clip(rnd(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1], 14), 16);
         ori[3] = clip(rnd(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0], 14), 16);
      end
      p.px = 32'(pos[0]); p.py = 32'(pos[1]); p.pz = 32'(pos[2]);
      p.qw = 16'(ori[0]); p.qx = 16'(ori[1]); p.qy = 16'(ori[2]); p.qz = 16'(ori[3]);
      pending.push_back(p);
   endfunction

   function void check_pose(pose_type got);
      pose_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result %h", $time, got);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (got.px !== e.px) begin
         $display("%0t: pos_x exp %0d got %0d", $time, e.px, got.px); errors++;
      end
      if (got.py !== e.py) begin
         $display("%0t: pos_y exp %0d got %0d", $time, e.py, got.py); errors++;
      end
      if (got.pz !== e.pz) begin
         $display("%0t: pos_z exp %0d got %0d", $time, e.pz, got.pz); errors++;
      end
      if (got.qw !== e.qw) begin
         $display("%0t: quat_w exp %0d got %0d", $time, e.qw, got.qw); errors++;
      end
      if (got.qx !== e.qx) begin
         $display("%0t: quat_x exp %0d got %0d", $time, e.qx, got.qx); errors++;
      end
      if (got.qy !== e.qy) begin
         $display("%0t: quat_y exp %0d got %0d", $time, e.qy, got.qy); errors++;
      end
      if (got.qz !== e.qz) begin
         $display("%0t: quat_z exp %0d got %0d", $time, e.qz, got.qz); errors++;
      end
   endfunction
endclass

module tb;
   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [119:0] req_tdata;   // vec_x, vec_y, vec_z, angle_degrees, zero pad
   logic [1:0]   req_tuser;   // command
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;   // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z

   pose_scoreboard_type board;
   longint cycles = 0;
   int     stall_mode = 0;

   quaternion_pose_update uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stall pattern, switched now and then
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 9) == 0);
         default: rsp_tready <= (cycles % 7) < 3;
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_pose('{pz: rsp_tdata[95:64], py: rsp_tdata[63:32],
            px: rsp_tdata[31:0], qz: rsp_tdata[159:144], qy: rsp_tdata[143:128],
            qx: rsp_tdata[127:112], qw: rsp_tdata[111:96]});
      end
   end

   always @(posedge clock) begin
      if (cycles > 64'd2000000) begin
         $display("[quaternion_pose_update] ERROR");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         3: return 32'($signed($urandom_range(0, 262144)) - 131072);
         default: return 32'($signed($urandom_range(0, 65536)) - 32768);
      endcase
   endfunction

   task automatic send_command(pose_cmd_type cmd, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [19:0] ang);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'd0, ang, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_command(cmd, {4'd0, ang, z, y, x});
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      int burst;
      pose_cmd_type c;
      board = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_MOVE_WORLD;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corner cases: saturation, wide angles, unit axes, local commands
      send_command(CMD_MOVE_WORLD, 32'h7fffffff, 32'h80000000, 32'h00010000, 20'd0);
      send_command(CMD_MOVE_WORLD, 32'h7fffffff, 32'h80000000, 32'hffff0000, 20'hfffff);
      send_command(CMD_MOVE_WORLD, 32'h80000000, 32'h7fffffff, 32'h0, 20'd0);
      send_command(CMD_TURN_WORLD, 32'h00010000, 32'h0, 32'h0, 20'd23040);
      send_command(CMD_TURN_WORLD, 32'h0, 32'h00010000, 32'h0, 20'h80000);
      send_command(CMD_TURN_WORLD, 32'h0, 32'h0, 32'h00010000, 20'h7ffff);
      send_command(CMD_TURN_LOCAL, 32'h00010000, 32'h00010000, 32'h0, 20'd46080);
      send_command(CMD_MOVE_LOCAL, 32'h00020000, 32'hfffe0000, 32'h00005000, 20'd0);
      send_command(CMD_TURN_WORLD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 20'd11520);
      send_command(CMD_TURN_LOCAL, 32'h80000000, 32'h7fffffff, 32'h80000000, 20'd92160);
      send_command(CMD_MOVE_LOCAL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 20'd0);
      send_command(CMD_TURN_WORLD, 32'h00050000, 32'h0, 32'h0, 20'd184320);
      send_command(CMD_TURN_WORLD, 32'h0, 32'h00010000, 32'h0, 20'hd3000);
      send_command(CMD_MOVE_LOCAL, 32'h00010000, 32'h00010000, 32'h00010000, 20'd0);
      // hold off until the pipeline has emptied
      drain();

      for (int n = 0; n < 1700;) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst; k++, n++) begin
            c = pose_cmd_type'($urandom_range(0, 3));
            send_command(c, pick_word(), pick_word(), pick_word(), 20'($urandom));
         end
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
      drain();
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("[quaternion_pose_update] OK");
      end else begin
         $display("[quaternion_pose_update] ERROR");
      end
      $finish;
   end
endmodule

[filelist.f]
rtl/qpu_pkg.sv
rtl/qpu_mac.sv
rtl/qpu_cordic.sv
rtl/quaternion_pose_update.sv
bench/tb.sv
